>>> rtl/isbc_pkg.sv
// shared types and constants for the imu static bias calibrator
// no dependencies; imported by every module of the block

package isbc_pkg;

   localparam int TS_W       = 32;
   localparam int SMP_W      = 24;
   localparam int SUM_W      = 40;
   localparam int SQ_W       = 63;
   localparam int PROD_W     = 47;
   localparam int LIM_W      = 46;
   localparam int ZOFF_W     = 24;
   localparam int BIAS_W     = 24;
   localparam int CFG_CNT_W  = 16;
   localparam int VAR_W      = 64;
   localparam int AXES       = 3;
   localparam int AXIS_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 46;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_PAD_W  = 3;

   localparam logic [LIM_W-1:0]     VAR_LIMIT_RESET = 46'd8388608;
   localparam logic [ZOFF_W-1:0]    Z_OFFSET_RESET  = 24'd0;
   localparam logic [CFG_CNT_W-1:0] DISCARD_RESET   = 16'd1000;
   localparam logic [CFG_CNT_W-1:0] WINDOW_RESET    = 16'd8000;
   localparam logic [AXIS_W-1:0]    LAST_AXIS       = 2'd2;

   typedef enum logic [1:0] {
      PH_DISCARD = 2'd0,
      PH_COLLECT = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VAR_LIMIT = 2'd0,
      CSR_Z_OFFSET  = 2'd1,
      CSR_DISCARD   = 2'd2,
      CSR_WINDOW    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_DISC_TEST,
      ST_SQUARE,
      ST_ADD,
      ST_DIV_SUM,
      ST_WAIT_SUM,
      ST_DIV_SQ,
      ST_WAIT_SQ,
      ST_VAR,
      ST_FINISH,
      ST_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic              capture;
      logic              mark_dup;
      logic              take_time;
      logic              count_step;
      logic              enter_collect;
      logic              square;
      logic              add_sq;
      logic              div_start;
      logic              div_sel_sq;
      logic              take_mean;
      logic              take_quot;
      logic              var_check;
      logic              latch_bias;
      logic              reject;
      logic              load_rsp;
      logic [AXIS_W-1:0] axis;
   } ctl_cmd_type;

   typedef struct packed {
      phase_type phase;
      logic      dup;
      logic      disc_hit;
      logic      win_hit;
      logic      div_done;
      logic      var_fail;
   } ctl_status_type;

endpackage

>>> rtl/isbc_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on isbc_pkg

module isbc_div #(
   parameter int NUM_W = 63,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   import isbc_pkg::*;

   localparam int CntW = $clog2(NUM_W);
   localparam logic [CntW-1:0] LastStep = CntW'(NUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      ge      = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = LastStep;
         num_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

endmodule

>>> rtl/isbc_datapath.sv
// datapath: config registers, per-axis accumulators, statistics and result register
// depends on isbc_pkg and isbc_div

module isbc_datapath #(
   parameter int SAMPLE_BITS = 24,
   parameter int COUNT_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [isbc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               csr_we,
   input  logic [isbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [isbc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  isbc_pkg::ctl_cmd_type              cmd,
   output isbc_pkg::ctl_status_type           status,
   output logic [isbc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import isbc_pkg::*;

   localparam int SextSh = SMP_W - SAMPLE_BITS;
   localparam int CntMaxInt = (1 << COUNT_BITS) - 1;
   localparam logic [COUNT_BITS-1:0] CntMax = COUNT_BITS'(CntMaxInt);
   localparam logic signed [BIAS_W-1:0] BiasMax = {1'b0, {(BIAS_W-1){1'b1}}};
   localparam logic signed [BIAS_W-1:0] BiasMin = {1'b1, {(BIAS_W-1){1'b0}}};

   function automatic logic [COUNT_BITS-1:0] limit_of(input logic [CFG_CNT_W-1:0] n);
      logic [COUNT_BITS-1:0] r;
      if (n == '0) begin
         r = COUNT_BITS'(1);
      end else if (32'(n) > CntMaxInt) begin
         r = CntMax;
      end else begin
         r = COUNT_BITS'(n);
      end
      return r;
   endfunction

   // configuration
   logic [LIM_W-1:0]     limit_ff, limit_in;
   logic [ZOFF_W-1:0]    zoff_ff, zoff_in;
   logic [CFG_CNT_W-1:0] disc_ff, disc_in;
   logic [CFG_CNT_W-1:0] win_ff, win_in;

   // control-side state
   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [TS_W-1:0]       last_ff, last_in;
   logic                  dup_ff, dup_in;
   logic                  rej_ff, rej_in;
   logic                  fail_ff, fail_in;
   logic signed [SUM_W-1:0]  sum_ff [AXES];
   logic signed [SUM_W-1:0]  sum_in [AXES];
   logic [SQ_W-1:0]          sq_ff [AXES];
   logic [SQ_W-1:0]          sq_in [AXES];
   logic signed [BIAS_W-1:0] bias_ff [AXES];
   logic signed [BIAS_W-1:0] bias_in [AXES];

   // payload
   logic [TS_W-1:0]          ts_ff;
   logic signed [SMP_W-1:0]  smp_ff [AXES];
   logic signed [SMP_W-1:0]  smp_in [AXES];
   logic [PROD_W-1:0]        prod_ff [AXES];
   logic [PROD_W-1:0]        prod_in [AXES];
   logic signed [BIAS_W-1:0] mean_ff [AXES];
   logic [SQ_W-1:0]          quot_ff;
   logic [PROD_W-1:0]        msq_ff;
   logic [RSP_DATA_W-1:0]    rsp_ff, rsp_in;

   logic signed [SMP_W-1:0]    raw [AXES];
   logic signed [2*SMP_W-1:0]  sq_full [AXES];
   logic signed [SUM_W-1:0]    sum_sel;
   logic [SUM_W-1:0]           sum_mag;
   logic                       sum_neg;
   logic [SQ_W-1:0]            div_numer;
   logic                       div_done;
   logic [SQ_W-1:0]            div_quot;
   logic [BIAS_W-1:0]          q_low;
   logic signed [BIAS_W-1:0]   mean_new;
   logic signed [BIAS_W-1:0]   mean_sel;
   logic signed [2*BIAS_W-1:0] msq_full;
   logic signed [VAR_W-1:0]    var_val;
   logic                       var_over;
   logic signed [BIAS_W:0]     bz_wide;
   logic signed [BIAS_W-1:0]   bz_sat;
   logic [COUNT_BITS-1:0]      disc_lim;
   logic [COUNT_BITS-1:0]      win_lim;

   // sample unpack and sign extension from SAMPLE_BITS
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         raw[i]    = req_tdata[TS_W + i*SMP_W +: SMP_W];
         smp_in[i] = (raw[i] <<< SextSh) >>> SextSh;
      end
   end

   // configuration writes
   always_comb begin
      limit_in = limit_ff;
      zoff_in  = zoff_ff;
      disc_in  = disc_ff;
      win_in   = win_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_VAR_LIMIT: limit_in = csr_wdata[LIM_W-1:0];
            CSR_Z_OFFSET:  zoff_in  = csr_wdata[ZOFF_W-1:0];
            CSR_DISCARD:   disc_in  = csr_wdata[CFG_CNT_W-1:0];
            CSR_WINDOW:    win_in   = csr_wdata[CFG_CNT_W-1:0];
            default:       limit_in = limit_ff;
         endcase
      end
   end

   assign disc_lim = limit_of(disc_ff);
   assign win_lim  = limit_of(win_ff);

   // divider operand selection
   always_comb begin
      sum_sel   = sum_ff[cmd.axis];
      sum_neg   = sum_sel[SUM_W-1];
      sum_mag   = sum_neg ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
      div_numer = cmd.div_sel_sq ? sq_ff[cmd.axis] : SQ_W'(sum_mag);
   end

   isbc_div #(
      .NUM_W (SQ_W),
      .DEN_W (COUNT_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (div_numer),
      .denom (cnt_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // statistics arithmetic
   always_comb begin
      q_low    = div_quot[BIAS_W-1:0];
      mean_new = sum_neg ? BIAS_W'(-q_low) : BIAS_W'(q_low);
      mean_sel = mean_ff[cmd.axis];
      msq_full = mean_sel * mean_sel;
      var_val  = $signed({1'b0, quot_ff}) - $signed(VAR_W'(msq_ff));
      var_over = !var_val[VAR_W-1] && (var_val[VAR_W-2:0] >= (VAR_W-1)'(limit_ff));
      bz_wide  = (BIAS_W+1)'(mean_ff[LAST_AXIS]) - (BIAS_W+1)'($signed(zoff_ff));
      if (bz_wide[BIAS_W] != bz_wide[BIAS_W-1]) begin
         bz_sat = bz_wide[BIAS_W] ? BiasMin : BiasMax;
      end else begin
         bz_sat = bz_wide[BIAS_W-1:0];
      end
   end

   // state updates
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      dup_in   = dup_ff;
      rej_in   = rej_ff;
      fail_in  = fail_ff;
      for (int i = 0; i < AXES; i++) begin
         sq_full[i] = smp_ff[i] * smp_ff[i];
         prod_in[i] = sq_full[i][PROD_W-1:0];
         sum_in[i]  = sum_ff[i];
         sq_in[i]   = sq_ff[i];
         bias_in[i] = bias_ff[i];
         if (cmd.reject) begin
            sum_in[i] = '0;
            sq_in[i]  = '0;
         end else begin
            if (cmd.square) begin
               sum_in[i] = sum_ff[i] + SUM_W'(smp_ff[i]);
            end
            if (cmd.add_sq) begin
               sq_in[i] = sq_ff[i] + SQ_W'(prod_ff[i]);
            end
         end
      end
      if (cmd.capture) begin
         dup_in  = 1'b0;
         rej_in  = 1'b0;
         fail_in = 1'b0;
      end
      if (cmd.mark_dup) begin
         dup_in = 1'b1;
      end
      if (cmd.take_time) begin
         last_in = ts_ff;
      end
      priority if (cmd.enter_collect || cmd.reject) begin
         cnt_in = '0;
      end else if (cmd.count_step && cnt_ff != CntMax) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.enter_collect) begin
         phase_in = PH_COLLECT;
      end
      if (cmd.var_check && var_over) begin
         fail_in = 1'b1;
      end
      if (cmd.reject) begin
         rej_in = 1'b1;
      end
      if (cmd.latch_bias) begin
         bias_in[0] = mean_ff[0];
         bias_in[1] = mean_ff[1];
         bias_in[2] = bz_sat;
         phase_in   = PH_DONE;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in = {RSP_PAD_W'(0), bias_ff[2], bias_ff[1], bias_ff[0],
                   rej_ff, dup_ff, (phase_ff == PH_DONE), phase_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= VAR_LIMIT_RESET;
         zoff_ff  <= Z_OFFSET_RESET;
         disc_ff  <= DISCARD_RESET;
         win_ff   <= WINDOW_RESET;
         phase_ff <= PH_DISCARD;
         cnt_ff   <= '0;
         last_ff  <= '0;
         dup_ff   <= 1'b0;
         rej_ff   <= 1'b0;
         fail_ff  <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            sum_ff[i]  <= '0;
            sq_ff[i]   <= '0;
            bias_ff[i] <= '0;
         end
      end else begin
         limit_ff <= limit_in;
         zoff_ff  <= zoff_in;
         disc_ff  <= disc_in;
         win_ff   <= win_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         dup_ff   <= dup_in;
         rej_ff   <= rej_in;
         fail_ff  <= fail_in;
         for (int i = 0; i < AXES; i++) begin
            sum_ff[i]  <= sum_in[i];
            sq_ff[i]   <= sq_in[i];
            bias_ff[i] <= bias_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ts_ff <= req_tdata[TS_W-1:0];
         for (int i = 0; i < AXES; i++) begin
            smp_ff[i] <= smp_in[i];
         end
      end
      if (cmd.square) begin
         for (int i = 0; i < AXES; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
      if (cmd.take_mean) begin
         mean_ff[cmd.axis] <= mean_new;
      end
      if (cmd.take_quot) begin
         quot_ff <= div_quot;
         msq_ff  <= msq_full[PROD_W-1:0];
      end
      rsp_ff <= rsp_in;
   end

   assign status.phase    = phase_ff;
   assign status.dup      = (ts_ff == last_ff);
   assign status.disc_hit = (cnt_ff >= disc_lim);
   assign status.win_hit  = (cnt_ff >= win_lim);
   assign status.div_done = div_done;
   assign status.var_fail = fail_ff;
   assign rsp_tdata       = rsp_ff;

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(phase_ff) == PH_DONE) |-> (phase_ff == PH_DONE))
      else $error("calibrated phase left");

   a_collect_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.enter_collect |=> (cnt_ff == '0 && phase_ff == PH_COLLECT))
      else $error("collection did not start from an empty count");

endmodule

>>> rtl/isbc_ctrl.sv
// controller state machine: item sequencing, window-end statistics, result handshake
// depends on isbc_pkg

module isbc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  isbc_pkg::ctl_status_type status,
   output isbc_pkg::ctl_cmd_type    cmd
);
   import isbc_pkg::*;

   ctl_state_type     state_ff, state_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            priority if (status.phase == PH_DONE || status.dup) begin
               state_in = ST_EMIT;
            end else if (status.phase == PH_DISCARD) begin
               state_in = ST_DISC_TEST;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_DISC_TEST: state_in = ST_EMIT;
         ST_SQUARE:    state_in = ST_ADD;
         ST_ADD: begin
            if (status.win_hit) begin
               axis_in  = '0;
               state_in = ST_DIV_SUM;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV_SUM: state_in = ST_WAIT_SUM;
         ST_WAIT_SUM: begin
            if (status.div_done) begin
               state_in = ST_DIV_SQ;
            end
         end
         ST_DIV_SQ: state_in = ST_WAIT_SQ;
         ST_WAIT_SQ: begin
            if (status.div_done) begin
               state_in = ST_VAR;
            end
         end
         ST_VAR: begin
            if (axis_ff == LAST_AXIS) begin
               state_in = ST_FINISH;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_DIV_SUM;
            end
         end
         ST_FINISH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_CLASSIFY: begin
            if (status.phase != PH_DONE) begin
               if (status.dup) begin
                  cmd.mark_dup = 1'b1;
               end else begin
                  cmd.take_time  = 1'b1;
                  cmd.count_step = (status.phase == PH_DISCARD);
               end
            end
         end
         ST_DISC_TEST: cmd.enter_collect = status.disc_hit;
         ST_SQUARE: begin
            cmd.square     = 1'b1;
            cmd.count_step = 1'b1;
         end
         ST_ADD:      cmd.add_sq = 1'b1;
         ST_DIV_SUM:  cmd.div_start = 1'b1;
         ST_WAIT_SUM: cmd.take_mean = status.div_done;
         ST_DIV_SQ: begin
            cmd.div_start  = 1'b1;
            cmd.div_sel_sq = 1'b1;
         end
         ST_WAIT_SQ:  cmd.take_quot = status.div_done;
         ST_VAR:      cmd.var_check = 1'b1;
         ST_FINISH: begin
            cmd.reject     = status.var_fail;
            cmd.latch_bias = !status.var_fail;
         end
         ST_EMIT:     cmd.load_rsp = out_free;
         default:     req_tready = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_WAIT_SUM || state_ff == ST_WAIT_SQ))
      else $error("division finished outside a wait state");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_EMIT)
      else $error("result raised outside emit");

   a_accept_classifies: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_CLASSIFY)
      else $error("accepted item not classified");

endmodule

>>> rtl/imu_static_bias_calibrator_top.sv
// top level of the imu static bias calibrator: controller plus datapath
// depends on isbc_pkg, isbc_ctrl, isbc_datapath (and isbc_div below it)
//
//   channel  dir  handshake           payload
//   req      in   req_tvalid/tready   timestamp, sample_x, sample_y, sample_z
//   rsp      out  rsp_tvalid/tready   phase, flags, bias_x, bias_y, bias_z
//   csr      in   csr_we              variance_limit, z_offset, discard/window counts
//
// one item at a time, one result per item; a repeated timestamp or a calibrated
// block runs classify and emit, a discarded item adds the discard test, a
// summed item square and add; a window end adds six shared-divider passes; the
// result register lets the next item be accepted while a result waits; reset
// is synchronous; a stalled result holds the finishing item in emit

module imu_static_bias_calibrator_top #(
   parameter int SAMPLE_BITS = 24,
   parameter int COUNT_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // timestamp[31:0], sample_x[55:32], sample_y[79:56], sample_z[103:80]
   input  logic [isbc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // phase[1:0], calibrated[2], duplicate_seen[3], window_rejected[4],
   // bias_x[28:5], bias_y[52:29], bias_z[76:53], zero fill[79:77]
   output logic [isbc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [isbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [isbc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import isbc_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   isbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   isbc_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> sim/tb.sv
// self-checking testbench for imu_static_bias_calibrator_top
// needs isbc_pkg and the block's rtl; predicts every status item in a small scoreboard class
`timescale 1ns / 1ps

module tb;
   import isbc_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [2:0][SMP_W-1:0] axis;
      logic [TS_W-1:0]       stamp;
   } imu_sample_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0]   fill;
      logic [2:0][BIAS_W-1:0] bias;
      logic                   window_rejected;
      logic                   duplicate_seen;
      logic                   calibrated;
      phase_type              phase;
   } status_item_type;

   typedef struct packed {
      phase_type              phase;
      logic [CFG_CNT_W-1:0]   count;
      logic [TS_W-1:0]        last_ts;
      logic [2:0][SUM_W-1:0]  sum;
      logic [2:0][SQ_W-1:0]   sq;
      logic [2:0][BIAS_W-1:0] bias;
   } calib_state_type;

   class calib_scoreboard;
      calib_state_type      state;
      logic [LIM_W-1:0]     var_limit;
      logic [ZOFF_W-1:0]    z_off;
      logic [CFG_CNT_W-1:0] discard_n;
      logic [CFG_CNT_W-1:0] window_n;
      status_item_type      expected_status[$];
      int                   errors, taken, checked, repeats, rejected;

      function new();
         state = '0;
         var_limit = VAR_LIMIT_RESET;
         z_off = Z_OFFSET_RESET;
         discard_n = DISCARD_RESET;
         window_n = WINDOW_RESET;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         unique case (idx)
            CSR_VAR_LIMIT: var_limit = value;
            CSR_Z_OFFSET:  z_off = value[ZOFF_W-1:0];
            CSR_DISCARD:   discard_n = value[CFG_CNT_W-1:0];
            CSR_WINDOW:    window_n = value[CFG_CNT_W-1:0];
         endcase
      endfunction

      function logic [CFG_CNT_W-1:0] at_least_one(logic [CFG_CNT_W-1:0] c);
         return (c == '0) ? CFG_CNT_W'(1) : c;
      endfunction

      function status_item_type advance(inout calib_state_type s, input imu_sample_type it);
         status_item_type r;
         longint       v, sq_term, n, var_now, bz;
         longint       mean [3];
         logic [63:0]  quot;
         logic         pass_all;
         int           a;
         r = '0;
         if (s.phase != PH_DONE) begin
            if (it.stamp == s.last_ts) begin
               r.duplicate_seen = 1'b1;
            end else begin
               s.last_ts = it.stamp;
               if (s.phase == PH_DISCARD) begin
                  if (s.count != '1) s.count = s.count + 1'b1;
                  if (s.count >= at_least_one(discard_n)) begin
                     s.count = '0;
                     s.phase = PH_COLLECT;
                  end
               end else begin
                  for (a = 0; a < 3; a++) begin
                     v = longint'($signed(it.axis[a]));
                     sq_term = v * v;
                     s.sum[a] = s.sum[a] + v[SUM_W-1:0];
                     s.sq[a] = s.sq[a] + sq_term[SQ_W-1:0];
                  end
                  if (s.count != '1) s.count = s.count + 1'b1;
                  if (s.count >= at_least_one(window_n)) begin
                     n = longint'(s.count);
                     pass_all = 1'b1;
                     for (a = 0; a < 3; a++) begin
                        mean[a] = longint'($signed(s.sum[a])) / n;
                        quot = {1'b0, s.sq[a]} / 64'(n);
                        var_now = longint'(quot) - mean[a] * mean[a];
                        if (var_now >= 0 && var_now >= longint'(var_limit)) pass_all = 1'b0;
                     end
                     if (pass_all) begin
                        // z bias saturates to the 24-bit range
                        bz = mean[2] - longint'($signed(z_off));
                        if (bz > 8388607) bz = 8388607;
                        if (bz < -8388608) bz = -8388608;
                        s.bias[0] = BIAS_W'(mean[0]);
                        s.bias[1] = BIAS_W'(mean[1]);
                        s.bias[2] = BIAS_W'(bz);
                        s.phase = PH_DONE;
                     end else begin
                        r.window_rejected = 1'b1;
                        s.count = '0;
                        s.sum = '0;
                        s.sq = '0;
                     end
                  end
               end
            end
         end
         r.phase = s.phase;
         r.calibrated = (s.phase == PH_DONE);
         r.bias = s.bias;
         return r;
      endfunction

      function phase_type peek_phase(imu_sample_type it);
         calib_state_type tmp;
         status_item_type r;
         tmp = state;
         r = advance(tmp, it);
         return r.phase;
      endfunction

      function void note_sample(imu_sample_type it);
         status_item_type r;
         r = advance(state, it);
         expected_status.push_back(r);
         taken++;
         if (r.duplicate_seen) repeats++;
         if (r.window_rejected) rejected++;
      endfunction

      task report(string what);
         $display("mismatch at status item %0d: %s", checked, what);
         errors++;
      endtask

      task check_status(status_item_type got);
         status_item_type want;
         int           a;
         if (expected_status.size() == 0) begin
            report($sformatf("status item %h with nothing expected", got));
            return;
         end
         want = expected_status.pop_front();
         if (got.phase !== want.phase)
            report($sformatf("phase %0d, want %0d", got.phase, want.phase));
         if (got.calibrated !== want.calibrated)
            report($sformatf("calibrated %b, want %b", got.calibrated, want.calibrated));
         if (got.duplicate_seen !== want.duplicate_seen)
            report($sformatf("duplicate_seen %b, want %b", got.duplicate_seen,
                             want.duplicate_seen));
         if (got.window_rejected !== want.window_rejected)
            report($sformatf("window_rejected %b, want %b", got.window_rejected,
                             want.window_rejected));
         for (a = 0; a < 3; a++)
            if (got.bias[a] !== want.bias[a])
               report($sformatf("bias axis %0d is %0d, want %0d", a,
                                $signed(got.bias[a]), $signed(want.bias[a])));
         checked++;
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   calib_scoreboard board = new();

   bit calm = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int center [3];
   int amp = 16;
   int noisy_pct = 0;

   imu_static_bias_calibrator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_status(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 20);
      end
   end

   task automatic send_sample(imu_sample_type it);
      int gap;
      gap = (!calm && $urandom_range(99) < 20) ? int'($urandom_range(6, 1)) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= it;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic offer(logic [TS_W-1:0] stamp, logic [SMP_W-1:0] x, logic [SMP_W-1:0] y,
                        logic [SMP_W-1:0] z);
      imu_sample_type it;
      it.stamp = stamp;
      it.axis[0] = x;
      it.axis[1] = y;
      it.axis[2] = z;
      send_sample(it);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.expected_status.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic setup(logic [LIM_W-1:0] limit, logic [ZOFF_W-1:0] zoff,
                        logic [CFG_CNT_W-1:0] disc, logic [CFG_CNT_W-1:0] win);
      logic [CSR_DATA_W-1:0] vals [4];
      int i;
      vals[0] = limit;
      vals[1] = CSR_DATA_W'(zoff);
      vals[2] = CSR_DATA_W'(disc);
      vals[3] = CSR_DATA_W'(win);
      wait_drained();
      for (i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(negedge clock);
         board.set_reg(csr_index_type'(i), vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic imu_sample_type make_sample();
      imu_sample_type it;
      int v, a, roll;
      roll = $urandom_range(99);
      if (roll < 8)
         it.stamp = board.state.last_ts;
      else if (roll < 13)
         it.stamp = $urandom;
      else
         it.stamp = board.state.last_ts + TS_W'($urandom_range(3, 1));
      for (a = 0; a < 3; a++) begin
         if ($urandom_range(99) < noisy_pct) begin
            it.axis[a] = SMP_W'($urandom);
         end else begin
            v = center[a] + int'($urandom_range(2 * amp)) - amp;
            if (v > 8388607) v = 8388607;
            if (v < -8388608) v = -8388608;
            it.axis[a] = SMP_W'(v);
         end
      end
      return it;
   endfunction

   // keeps a window from passing before the last phase
   function automatic imu_sample_type spoil(imu_sample_type it);
      int k;
      for (k = 0; k < 3 && board.peek_phase(it) == PH_DONE; k++)
         it.axis[$urandom_range(2)] = SMP_W'($urandom);
      if (board.peek_phase(it) == PH_DONE) it.stamp = board.state.last_ts;
      return it;
   endfunction

   function automatic void pick_centers();
      int a;
      for (a = 0; a < 3; a++) begin
         case ($urandom_range(5))
            0:       center[a] = 8388607;
            1:       center[a] = -8388608;
            default: center[a] = int'($urandom_range(16000000)) - 8000000;
         endcase
      end
   endfunction

   initial begin
      logic [LIM_W-1:0]     limit;
      logic [ZOFF_W-1:0]    zoff;
      logic [CFG_CNT_W-1:0] win;
      int                   phase_no, n;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: stamp zero, extremes, zero counts, count changes mid-run
      offer(32'd0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      offer(32'd1, 24'h800000, 24'h800000, 24'h800000);
      offer(32'd1, 24'h000000, 24'h000000, 24'h000000);
      setup('0, 24'h7FFFFF, 16'hFFFF, 16'd0);
      offer(32'hFFFFFFFF, 24'h5A5A5A, 24'hA5A5A5, 24'h123456);
      setup('0, 24'h800000, 16'd0, 16'd0);
      offer(32'd0, 24'h000000, 24'h000000, 24'h000000);
      offer(32'd2, 24'h7FFFFF, 24'h800000, 24'h000000);
      offer(32'd3, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
      setup('0, 24'h000000, 16'd0, 16'hFFFF);
      offer(32'd4, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      offer(32'd5, 24'h800000, 24'h800000, 24'h800000);
      offer(32'd5, 24'h000001, 24'h000001, 24'h000001);
      offer(32'd6, 24'h000001, 24'h000002, 24'h000003);
      setup(46'd1, 24'h000000, 16'd0, 16'd2);
      offer(32'd7, 24'h000000, 24'h000000, 24'h000000);
      offer(32'd8, 24'h000005, 24'h000009, 24'h000009);
      offer(32'd9, 24'h000006, 24'h000009, 24'h000009);
      offer(32'd10, 24'hFFFFFB, 24'h000009, 24'h000009);
      offer(32'd11, 24'hFFFFFA, 24'h000009, 24'h000009);

      // random windows that are kept from passing
      for (phase_no = 0; phase_no < 8; phase_no++) begin
         limit = ($urandom_range(4) == 0) ? '0 :
                 ((LIM_W'(1) << $urandom_range(36, 8)) | LIM_W'($urandom_range(255)));
         win = ($urandom_range(5) == 0) ? CFG_CNT_W'($urandom_range(40, 13)) :
                                          CFG_CNT_W'($urandom_range(12, 2));
         setup(limit, ZOFF_W'($urandom), CFG_CNT_W'($urandom), win);
         pick_centers();
         amp = 1 << $urandom_range(20, 2);
         noisy_pct = $urandom_range(30);
         calm = (phase_no == 2);
         if (phase_no == 4) hold_request = 1'b1;
         repeat (52) send_sample(spoil(make_sample()));
         calm = 1'b0;
      end

      // last phase: quiet data that calibrates, z bias often at saturation
      pick_centers();
      case ($urandom_range(2))
         0: begin
            center[2] = 8388000;
            zoff = 24'h800000;
         end
         1: begin
            center[2] = -8388000;
            zoff = 24'h7FFFFF;
         end
         default: zoff = ZOFF_W'($urandom);
      endcase
      amp = 1 << $urandom_range(8, 0);
      noisy_pct = 0;
      limit = $urandom_range(1) ? '1 : (LIM_W'(1) << 30);
      setup(limit, zoff, CFG_CNT_W'($urandom), CFG_CNT_W'($urandom_range(16, 2)));
      n = 0;
      while (board.state.phase != PH_DONE && n < 300) begin
         send_sample(make_sample());
         n++;
      end
      repeat (12) send_sample(make_sample());

      wait_drained();
      repeat (12) @(negedge clock);
      $display("covered %0d samples: %0d repeated stamps, %0d rejected windows",
               board.taken, board.repeats, board.rejected);
      $display("calibrated at the end: %0d, bias %0d %0d %0d",
               board.state.phase == PH_DONE, $signed(board.state.bias[0]),
               $signed(board.state.bias[1]), $signed(board.state.bias[2]));
      if (board.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
